FILE: hw/rtl/res_pkg.sv
package res_pkg;

	localparam int PosWidth = 8;
	localparam int CfgCount = 2;
	localparam int CfgIdxWidth = $clog2(CfgCount);

	typedef enum logic [1:0] {
		EV_IDLE = 2'd0,
		EV_PUSH = 2'd1,
		EV_CCW  = 2'd2,
		EV_CW   = 2'd3
	} event_t;

	typedef enum logic [CfgIdxWidth-1:0] {
		REG_POSITION_MIN = 1'd0,
		REG_POSITION_MAX = 1'd1
	} cfg_reg_t;

	typedef struct packed {
		logic                primed;
		logic                armed;
		logic                last_a;
		logic [PosWidth-1:0] pos;
		event_t              ev;
	} scan_state_t;

	localparam logic [PosWidth-1:0] PosReset = 8'd127;
	localparam logic [PosWidth-1:0] MinReset = 8'd0;
	localparam logic [PosWidth-1:0] MaxReset = 8'd255;

endpackage

FILE: hw/rtl/res_step.sv
module res_step import res_pkg::*; (
	input  scan_state_t         cur,
	input  logic                req_type,
	input  logic                button_level,
	input  logic                chan_a_level,
	input  logic                chan_b_level,
	input  logic [PosWidth-1:0] position_min,
	input  logic [PosWidth-1:0] position_max,
	output scan_state_t         nxt,
	output event_t              ev_out
);

	logic signed [PosWidth+1:0] pos_w;
	logic signed [PosWidth+1:0] pos_hi;
	logic signed [PosWidth+1:0] pos_lo;
	logic signed [PosWidth+1:0] lim_max;
	logic signed [PosWidth+1:0] lim_min;

	assign lim_max = $signed({2'b00, position_max});
	assign lim_min = $signed({2'b00, position_min});

	always_comb begin
		nxt = cur;
		pos_w = $signed({2'b00, cur.pos});
		if (req_type) begin
			nxt.ev = EV_IDLE;
		end else if (!cur.primed) begin
			// first tick only captures channel A
			nxt.last_a = chan_a_level;
			nxt.primed = 1'b1;
		end else begin
			if (!button_level) begin
				if (cur.armed) begin
					nxt.armed = 1'b0;
					nxt.ev = EV_PUSH;
				end
			end else begin
				nxt.armed = 1'b1;
			end
			// rotation overrides a push in the same tick
			if (chan_a_level != cur.last_a) begin
				nxt.last_a = chan_a_level;
				if (chan_a_level == chan_b_level) begin
					pos_w = pos_w - 10'sd1;
					nxt.ev = EV_CCW;
				end else begin
					pos_w = pos_w + 10'sd1;
					nxt.ev = EV_CW;
				end
			end
		end
		pos_hi = (pos_w > lim_max) ? lim_max : pos_w;
		pos_lo = (pos_hi < lim_min) ? lim_min : pos_hi;
		if (!req_type && cur.primed) begin
			nxt.pos = pos_lo[PosWidth-1:0];
		end
		ev_out = req_type ? cur.ev : nxt.ev;
	end

endmodule

FILE: hw/rtl/rotary_encoder_scanner.sv
// Quadrature rotary encoder decoder with push button.
// Input channel: one request per accepted cycle (in_valid high, in_stall low).
//   req_type 0 is a sample tick carrying button, channel A and channel B levels;
//   req_type 1 reads the latched event and clears it.
// Output channel: one result per request, position and event_code, accepted
//   when out_valid is high and out_stall is low.
// Path: a request is registered on accept in the input register, then evaluated
//   against the scanner state into the output register once that register can
//   take it (empty, or out_stall low); out_valid rises with that load.
// Throughput: one request per cycle while not stalled; the state update is a
//   single short pass (compare, increment, two-sided clamp) between the input
//   and result registers, so back-to-back requests see each other's state at once.
// Stall: while out_stall holds a full output register, the input register
//   holds its request and in_stall rises; nothing is dropped.
// Reset: position 127, event idle, button armed, limits 0 and 255; the first
//   sample tick after reset only captures channel A.
// Configuration: wr_en with wr_index 0 writes position_min, 1 position_max;
//   write only while no request is in flight.
module rotary_encoder_scanner import res_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CfgIdxWidth-1:0] wr_index,
	input  logic [PosWidth-1:0]    wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   req_type,
	input  logic                   button_level,
	input  logic                   chan_a_level,
	input  logic                   chan_b_level,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [PosWidth-1:0]    position,
	output logic [1:0]             event_code
);

	logic [PosWidth-1:0] pos_min_q;
	logic [PosWidth-1:0] pos_max_q;

	logic s1_valid_q;
	logic req_s1;
	logic btn_s1;
	logic a_s1;
	logic b_s1;

	scan_state_t state_q;
	scan_state_t state_nxt;
	event_t      ev_res;

	logic                out_valid_q;
	logic [PosWidth-1:0] pos_out_q;
	event_t              ev_out_q;

	logic adv;
	logic in_acc;

	assign adv = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !adv;
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_min_q <= MinReset;
			pos_max_q <= MaxReset;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_POSITION_MIN: pos_min_q <= wr_data;
				REG_POSITION_MAX: pos_max_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1 <= req_type;
			btn_s1 <= button_level;
			a_s1 <= chan_a_level;
			b_s1 <= chan_b_level;
		end
	end

	res_step u_step (
		.cur          (state_q),
		.req_type     (req_s1),
		.button_level (btn_s1),
		.chan_a_level (a_s1),
		.chan_b_level (b_s1),
		.position_min (pos_min_q),
		.position_max (pos_max_q),
		.nxt          (state_nxt),
		.ev_out       (ev_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.primed <= 1'b0;
			state_q.armed <= 1'b1;
			state_q.last_a <= 1'b0;
			state_q.pos <= PosReset;
			state_q.ev <= EV_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				state_q <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_out_q <= state_nxt.pos;
			ev_out_q <= ev_res;
		end
	end

	assign out_valid = out_valid_q;
	assign position = pos_out_q;
	assign event_code = ev_out_q;

`ifndef SYNTHESIS
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_s1 |=> state_q.ev == EV_IDLE)
		else $error("read request did not clear the event latch");

	a_first_tick_holds_pos: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !state_q.primed |=> state_q.pos == $past(state_q.pos))
		else $error("first tick moved the position");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q && out_valid_q)
		else $error("input stalled with room downstream");

	a_adv_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced request did not reach the output register");
`endif

endmodule
